// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL top file.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define AST_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define AST_IMPL(lbl, pre, post)
`define AST_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/drcq_pkg.sv =====
// Types, constants and helpers for the dirty rectangle coalescing queue.
// No dependencies.
package drcq_pkg;
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_OPTIMIZE = 2'd1;
  localparam logic [1:0] KIND_POP = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [2:0] REG_PATCH_W = 3'd0;
  localparam logic [2:0] REG_PATCH_H = 3'd1;
  localparam logic [2:0] REG_MERGE_ALPHA = 3'd2;
  localparam logic [2:0] REG_MCOLL_ALPHA = 3'd3;
  localparam logic [2:0] REG_COLL_ALPHA = 3'd4;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } box_t;

  typedef struct packed {
    logic [15:0] node;
    logic upd;
    box_t r;
    box_t c;
  } entry_t;

  function automatic logic group_eq(entry_t a, entry_t b);
    return (a.node == b.node) && (a.upd == b.upd) && (a.c == b.c);
  endfunction
endpackage

// ===== hdl/dirty_rect_coalescing_queue_top.sv =====
// Insert scans from the tail and, after a join, runs a collect pass; every entry visited
// is read and unioned, and when its group matches and the union fits, its areas are
// weighed on the one shared multiplier. Pop reads every entry once; optimize, with more
// than one entry, reads the head and runs a collect pass, which ends with a write-back.
// One result beat per command, never held off by the receiver; the next command can be
// accepted the cycle after it. Sync reset empties the queue; needs drcq_pkg and macros.
`include "assert_macros.svh"
module dirty_rect_coalescing_queue_top (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_kind,
  input  logic [15:0] in_node_id,
  input  logic in_update_type,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic [14:0] in_rect_w,
  input  logic [14:0] in_rect_h,
  input  logic signed [15:0] in_crop_x,
  input  logic signed [15:0] in_crop_y,
  input  logic [14:0] in_crop_w,
  input  logic [14:0] in_crop_h,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic out_popped_valid,
  output logic [15:0] out_out_node,
  output logic out_out_type,
  output logic signed [15:0] out_out_x,
  output logic signed [15:0] out_out_y,
  output logic [14:0] out_out_w,
  output logic [14:0] out_out_h,
  output logic signed [15:0] out_out_crop_x,
  output logic signed [15:0] out_out_crop_y,
  output logic [14:0] out_out_crop_w,
  output logic [14:0] out_out_crop_h,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import drcq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_UNION, ST_MUL_SA, ST_MUL_SB, ST_MUL_U, ST_MUL_A, ST_CMP,
    ST_FINAL, ST_DONE
  } state_t;
  typedef enum logic [1:0] { PH_SCAN, PH_COLL, PH_OPT0, PH_POP } phase_t;

  state_t state_r;
  phase_t phase_r;
  logic [1:0] op_r;
  logic [14:0] patch_w_r, patch_h_r;
  logic [9:0] merge_alpha_r, mcoll_alpha_r, coll_alpha_r;
  logic [CNT_W-1:0] count_r, wp_r;
  logic [IDX_W-1:0] idx_r, bi_r, nbi_r;
  entry_t key_r;
  box_t base_r;
  entry_t rd_data_r;
  entry_t mem_r [QUEUE_DEPTH];
  logic [30:0] sum_r;
  logic [29:0] area_r;
  logic [40:0] prod_r;
  logic [1:0] status_r;
  logic popped_r;
  entry_t pop_r;

  // Config port
  logic cfg_wr;
  logic [2:0] cfg_idx;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  always_comb begin
    unique case (cfg_idx)
      REG_PATCH_W:     prdata = {17'd0, patch_w_r};
      REG_PATCH_H:     prdata = {17'd0, patch_h_r};
      REG_MERGE_ALPHA: prdata = {22'd0, merge_alpha_r};
      REG_MCOLL_ALPHA: prdata = {22'd0, mcoll_alpha_r};
      REG_COLL_ALPHA:  prdata = {22'd0, coll_alpha_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Union of the running base with the entry just read
  entry_t e;
  box_t u;
  logic signed [17:0] r1, r2, b1, b2, lx, ty, rx, by, uw, uh;
  logic base_z, add_z, fits, match, early_fail, join_ok, last;
  logic fail_now, ok_now, accept;
  logic [9:0] alpha;
  logic [30:0] mul_a;
  logic [14:0] mul_b;
  logic [45:0] mul_p;

  assign e = rd_data_r;
  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);

  always_comb begin
    base_z = (base_r.w == 15'd0) && (base_r.h == 15'd0);
    add_z = (e.r.w == 15'd0) && (e.r.h == 15'd0);
    r1 = 18'(base_r.x) + $signed({3'd0, base_r.w});
    r2 = 18'(e.r.x) + $signed({3'd0, e.r.w});
    b1 = 18'(base_r.y) + $signed({3'd0, base_r.h});
    b2 = 18'(e.r.y) + $signed({3'd0, e.r.h});
    lx = (base_r.x < e.r.x) ? 18'(base_r.x) : 18'(e.r.x);
    ty = (base_r.y < e.r.y) ? 18'(base_r.y) : 18'(e.r.y);
    rx = (r1 > r2) ? r1 : r2;
    by = (b1 > b2) ? b1 : b2;
    if (base_z) begin
      uw = $signed({3'd0, e.r.w});
      uh = $signed({3'd0, e.r.h});
      u.x = e.r.x;
      u.y = e.r.y;
    end else if (add_z) begin
      uw = $signed({3'd0, base_r.w});
      uh = $signed({3'd0, base_r.h});
      u.x = base_r.x;
      u.y = base_r.y;
    end else begin
      uw = rx - lx;
      uh = by - ty;
      u.x = lx[15:0];
      u.y = ty[15:0];
    end
    u.w = uw[14:0];
    u.h = uh[14:0];
    fits = (uw <= $signed({3'd0, patch_w_r})) && (uh <= $signed({3'd0, patch_h_r}));
    match = group_eq(e, key_r) && !((phase_r == PH_COLL) && (idx_r == bi_r));
    early_fail = !(match && fits);
    join_ok = (sum_r != 31'd0) && ({3'd0, area_r, 8'd0} < prod_r);
    last = (idx_r == IDX_W'(count_r - CNT_W'(1)));
    fail_now = ((phase_r == PH_SCAN) || (phase_r == PH_COLL)) &&
               (((state_r == ST_UNION) && early_fail) || ((state_r == ST_CMP) && !join_ok));
    ok_now = (state_r == ST_CMP) && join_ok;
  end

  always_comb begin
    if (phase_r == PH_SCAN) alpha = merge_alpha_r;
    else if (op_r == KIND_OPTIMIZE) alpha = coll_alpha_r;
    else alpha = mcoll_alpha_r;
  end

  // The one shared multiplier
  always_comb begin
    unique case (state_r)
      ST_MUL_SA: begin mul_a = {16'd0, base_r.w}; mul_b = base_r.h; end
      ST_MUL_SB: begin mul_a = {16'd0, e.r.w}; mul_b = e.r.h; end
      ST_MUL_U:  begin mul_a = {16'd0, u.w}; mul_b = u.h; end
      ST_MUL_A:  begin mul_a = sum_r; mul_b = {5'd0, alpha}; end
      default:   begin mul_a = 31'd0; mul_b = 15'd0; end
    endcase
    mul_p = 46'(mul_a) * 46'(mul_b);
  end

  // Memory write port
  logic mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t mem_wd, kb;
  always_comb begin
    kb = key_r;
    kb.r = base_r;
    mem_we = 1'b0;
    mem_wa = count_r[IDX_W-1:0];
    mem_wd = kb;
    if (state_r == ST_IDLE) begin
      mem_we = accept && (in_kind == KIND_INSERT) && (count_r == CNT_W'(0));
      mem_wa = '0;
      mem_wd = {in_node_id, in_update_type, in_rect_x, in_rect_y, in_rect_w, in_rect_h,
                in_crop_x, in_crop_y, in_crop_w, in_crop_h};
    end else if (fail_now && (phase_r == PH_SCAN)) begin
      mem_we = (idx_r == '0) && (count_r != CNT_W'(QUEUE_DEPTH));
    end else if (fail_now) begin
      mem_we = 1'b1;
      mem_wa = wp_r[IDX_W-1:0];
      mem_wd = e;
    end else if ((state_r == ST_UNION) && (phase_r == PH_POP)) begin
      mem_we = (idx_r != '0);
      mem_wa = idx_r - IDX_W'(1);
      mem_wd = e;
    end else if (state_r == ST_FINAL) begin
      mem_we = 1'b1;
      mem_wa = nbi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (state_r == ST_READ) rd_data_r <= mem_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_SCAN;
      op_r <= KIND_INSERT;
      count_r <= '0;
      patch_w_r <= 15'd512;
      patch_h_r <= 15'd512;
      merge_alpha_r <= 10'd256;
      mcoll_alpha_r <= 10'd256;
      coll_alpha_r <= 10'd256;
      status_r <= STAT_DONE;
      popped_r <= 1'b0;
      pop_r <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_PATCH_W:     patch_w_r <= pwdata[14:0];
          REG_PATCH_H:     patch_h_r <= pwdata[14:0];
          REG_MERGE_ALPHA: merge_alpha_r <= pwdata[9:0];
          REG_MCOLL_ALPHA: mcoll_alpha_r <= pwdata[9:0];
          REG_COLL_ALPHA:  coll_alpha_r <= pwdata[9:0];
          default: ;
        endcase
      end
      priority if (fail_now) begin
        if (phase_r == PH_SCAN) begin
          if (idx_r == '0) begin
            if (count_r == CNT_W'(QUEUE_DEPTH)) status_r <= STAT_FULL;
            else count_r <= count_r + CNT_W'(1);
            state_r <= ST_DONE;
          end else begin
            idx_r <= idx_r - IDX_W'(1);
            state_r <= ST_READ;
          end
        end else begin
          // Entry stays: it was compacted to the write pointer.
          if (idx_r == bi_r) nbi_r <= wp_r[IDX_W-1:0];
          wp_r <= wp_r + CNT_W'(1);
          if (last) state_r <= ST_FINAL;
          else begin
            idx_r <= idx_r + IDX_W'(1);
            state_r <= ST_READ;
          end
        end
      end else if (ok_now) begin
        base_r <= u;
        if (phase_r == PH_SCAN) begin
          bi_r <= idx_r;
          phase_r <= PH_COLL;
          idx_r <= '0;
          wp_r <= '0;
          state_r <= ST_READ;
        end else if (last) state_r <= ST_FINAL;
        else begin
          idx_r <= idx_r + IDX_W'(1);
          state_r <= ST_READ;
        end
      end else begin
        unique case (state_r)
          ST_IDLE: begin
            if (accept) begin
              op_r <= in_kind;
              status_r <= STAT_DONE;
              popped_r <= 1'b0;
              pop_r <= '0;
              idx_r <= '0;
              state_r <= ST_DONE;
              unique case (in_kind)
                KIND_INSERT: begin
                  key_r <= {in_node_id, in_update_type, in_rect_x, in_rect_y, in_rect_w,
                            in_rect_h, in_crop_x, in_crop_y, in_crop_w, in_crop_h};
                  base_r <= {in_rect_x, in_rect_y, in_rect_w, in_rect_h};
                  phase_r <= PH_SCAN;
                  if (count_r == CNT_W'(0)) count_r <= CNT_W'(1);
                  else begin
                    idx_r <= IDX_W'(count_r - CNT_W'(1));
                    state_r <= ST_READ;
                  end
                end
                KIND_OPTIMIZE: begin
                  phase_r <= PH_OPT0;
                  if (count_r > CNT_W'(1)) state_r <= ST_READ;
                end
                KIND_POP: begin
                  phase_r <= PH_POP;
                  if (count_r == CNT_W'(0)) status_r <= STAT_EMPTY;
                  else state_r <= ST_READ;
                end
                default: ;
              endcase
            end
          end
          ST_READ: state_r <= ST_UNION;
          ST_UNION: begin
            if (phase_r == PH_OPT0) begin
              key_r <= e;
              base_r <= e.r;
              bi_r <= '0;
              phase_r <= PH_COLL;
              idx_r <= '0;
              wp_r <= '0;
              state_r <= ST_READ;
            end else if (phase_r == PH_POP) begin
              if (idx_r == '0) begin
                pop_r <= e;
                popped_r <= 1'b1;
              end
              if (last) begin
                count_r <= count_r - CNT_W'(1);
                state_r <= ST_DONE;
              end else begin
                idx_r <= idx_r + IDX_W'(1);
                state_r <= ST_READ;
              end
            end else state_r <= ST_MUL_SA;
          end
          ST_MUL_SA: begin
            sum_r <= 31'(mul_p);
            state_r <= ST_MUL_SB;
          end
          ST_MUL_SB: begin
            sum_r <= sum_r + 31'(mul_p);
            state_r <= ST_MUL_U;
          end
          ST_MUL_U: begin
            area_r <= 30'(mul_p);
            state_r <= ST_MUL_A;
          end
          ST_MUL_A: begin
            prod_r <= 41'(mul_p);
            state_r <= ST_CMP;
          end
          ST_CMP: state_r <= ST_DONE;
          ST_FINAL: begin
            count_r <= wp_r;
            state_r <= ST_DONE;
          end
          ST_DONE: state_r <= ST_IDLE;
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

  assign out_valid = (state_r == ST_DONE);
  assign out_status = status_r;
  assign out_popped_valid = popped_r;
  assign out_out_node = pop_r.node;
  assign out_out_type = pop_r.upd;
  assign out_out_x = pop_r.r.x;
  assign out_out_y = pop_r.r.y;
  assign out_out_w = pop_r.r.w;
  assign out_out_h = pop_r.r.h;
  assign out_out_crop_x = pop_r.c.x;
  assign out_out_crop_y = pop_r.c.y;
  assign out_out_crop_w = pop_r.c.w;
  assign out_out_crop_h = pop_r.c.h;

  `AST_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))
  `AST_IMPL(a_pop_status, out_valid && out_popped_valid, out_status == STAT_DONE)
  `AST_NEXT(a_accept_busy, accept, busy)
  `AST_IMPL(a_wp_bound, state_r == ST_FINAL, wp_r <= count_r)
endmodule

// ===== tb/dirty_rect_coalescing_queue_top_tb.sv =====
// Self-checking testbench for dirty_rect_coalescing_queue_top: a scoreboard class
// mirrors the coalescing queue and checks every result beat in order.
// Depends on drcq_pkg and the RTL of the block.
`timescale 1ns / 100ps

module dirty_rect_coalescing_queue_top_tb;
  import drcq_pkg::*;

  localparam int LIMIT_CYCLES = 6000000;
  localparam int RAND_ITEMS = 1400;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } rect_s;

  typedef struct {
    int node;
    int upd;
    rect_s r;
    rect_s c;
  } req_s;

  typedef struct {
    logic [1:0] kind;
    logic [15:0] node;
    logic upd;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [14:0] cw;
    logic [14:0] ch;
  } cmd_s;

  typedef struct packed {
    logic [1:0] status;
    logic popped;
    logic [15:0] node;
    logic upd;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [14:0] cw;
    logic [14:0] ch;
  } beat_s;

  class rect_queue_scoreboard;
    int patch_w, patch_h, merge_a, merge_coll_a, coll_a;
    req_s pending[$];
    beat_s expected[$];
    int mismatches, pops, drops, checked;

    function new();
      patch_w = 512;
      patch_h = 512;
      merge_a = 256;
      merge_coll_a = 256;
      coll_a = 256;
      mismatches = 0;
      pops = 0;
      drops = 0;
      checked = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] val);
      case (idx)
        REG_PATCH_W: patch_w = int'(val[14:0]);
        REG_PATCH_H: patch_h = int'(val[14:0]);
        REG_MERGE_ALPHA: merge_a = int'(val[9:0]);
        REG_MCOLL_ALPHA: merge_coll_a = int'(val[9:0]);
        REG_COLL_ALPHA: coll_a = int'(val[9:0]);
        default: ;
      endcase
    endfunction

    // Bounding-box union, accepted when it fits the patch and is tight enough.
    function bit try_union(inout rect_s base, input rect_s add, input int alpha);
      rect_s u;
      longint sum, area;
      int r, b;
      if (base.w == 0 && base.h == 0) u = add;
      else if (add.w == 0 && add.h == 0) u = base;
      else begin
        u.x = base.x < add.x ? base.x : add.x;
        u.y = base.y < add.y ? base.y : add.y;
        r = (base.x + base.w) > (add.x + add.w) ? base.x + base.w : add.x + add.w;
        b = (base.y + base.h) > (add.y + add.h) ? base.y + base.h : add.y + add.h;
        u.w = r - u.x;
        u.h = b - u.y;
      end
      if (u.w > patch_w || u.h > patch_h) return 0;
      sum = longint'(base.w) * base.h + longint'(add.w) * add.h;
      if (sum <= 0) return 0;
      area = longint'(u.w) * u.h;
      if (area * 256 < longint'(alpha) * sum) begin
        base = u;
        return 1;
      end
      return 0;
    endfunction

    function bit same_group(req_s a, req_s b);
      return a.node == b.node && a.upd == b.upd && a.c.x == b.c.x && a.c.y == b.c.y &&
             a.c.w == b.c.w && a.c.h == b.c.h;
    endfunction

    function void absorb_into(int bi, rect_s grown, int alpha);
      int i;
      i = 0;
      while (i < pending.size()) begin
        if (i != bi && same_group(pending[i], pending[bi]) &&
            try_union(grown, pending[i].r, alpha)) begin
          pending.delete(i);
          if (i < bi) bi--;
        end else i++;
      end
      pending[bi].r = grown;
    endfunction

    function void note_cmd(cmd_s c);
      req_s rq;
      rect_s base;
      beat_s res;
      int found;
      res = '0;
      case (c.kind)
        KIND_INSERT: begin
          rq.node = int'(c.node);
          rq.upd = int'(c.upd);
          rq.r = '{int'($signed(c.x)), int'($signed(c.y)), int'(c.w), int'(c.h)};
          rq.c = '{int'($signed(c.cx)), int'($signed(c.cy)), int'(c.cw), int'(c.ch)};
          base = rq.r;
          found = -1;
          for (int i = pending.size() - 1; i >= 0; i--) begin
            if (same_group(pending[i], rq) && try_union(base, pending[i].r, merge_a)) begin
              found = i;
              break;
            end
          end
          if (found >= 0) absorb_into(found, base, merge_coll_a);
          else if (pending.size() >= QUEUE_DEPTH) begin
            res.status = STAT_FULL;
            drops++;
          end else pending.push_back(rq);
        end
        KIND_OPTIMIZE: begin
          if (pending.size() > 1) absorb_into(0, pending[0].r, coll_a);
        end
        KIND_POP: begin
          if (pending.size() == 0) res.status = STAT_EMPTY;
          else begin
            rq = pending.pop_front();
            res.popped = 1'b1;
            res.node = 16'(rq.node);
            res.upd = 1'(rq.upd);
            res.x = 16'(rq.r.x);
            res.y = 16'(rq.r.y);
            res.w = 15'(rq.r.w);
            res.h = 15'(rq.r.h);
            res.cx = 16'(rq.c.x);
            res.cy = 16'(rq.c.y);
            res.cw = 15'(rq.c.w);
            res.ch = 15'(rq.c.h);
            pops++;
          end
        end
        default: ;
      endcase
      expected.push_back(res);
    endfunction

    function void check_beat(beat_s got);
      beat_s exp;
      checked++;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp = expected.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs:", checked);
          $display("  expected %p", exp);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [1:0] in_kind;
  logic [15:0] in_node_id;
  logic in_update_type;
  logic signed [15:0] in_rect_x, in_rect_y, in_crop_x, in_crop_y;
  logic [14:0] in_rect_w, in_rect_h, in_crop_w, in_crop_h;
  logic out_valid, out_popped_valid, out_out_type;
  logic [1:0] out_status;
  logic [15:0] out_out_node;
  logic signed [15:0] out_out_x, out_out_y, out_out_crop_x, out_out_crop_y;
  logic [14:0] out_out_w, out_out_h, out_out_crop_w, out_out_crop_h;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  rect_queue_scoreboard sb;
  int cycle_count = 0;
  int sender_idle_pct;
  int items_sent;

  dirty_rect_coalescing_queue_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_node_id(in_node_id), .in_update_type(in_update_type),
    .in_rect_x(in_rect_x), .in_rect_y(in_rect_y), .in_rect_w(in_rect_w),
    .in_rect_h(in_rect_h), .in_crop_x(in_crop_x), .in_crop_y(in_crop_y),
    .in_crop_w(in_crop_w), .in_crop_h(in_crop_h),
    .out_valid(out_valid), .out_status(out_status), .out_popped_valid(out_popped_valid),
    .out_out_node(out_out_node), .out_out_type(out_out_type),
    .out_out_x(out_out_x), .out_out_y(out_out_y), .out_out_w(out_out_w),
    .out_out_h(out_out_h), .out_out_crop_x(out_out_crop_x),
    .out_out_crop_y(out_out_crop_y), .out_out_crop_w(out_out_crop_w),
    .out_out_crop_h(out_out_crop_h),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("dirty_rect_coalescing_queue_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_beat('{out_status, out_popped_valid, out_out_node, out_out_type,
                      out_out_x, out_out_y, out_out_w, out_out_h, out_out_crop_x,
                      out_out_crop_y, out_out_crop_w, out_out_crop_h});
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(cmd_s c);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_kind = c.kind;
    in_node_id = c.node;
    in_update_type = c.upd;
    in_rect_x = c.x;
    in_rect_y = c.y;
    in_rect_w = c.w;
    in_rect_h = c.h;
    in_crop_x = c.cx;
    in_crop_y = c.cy;
    in_crop_w = c.cw;
    in_crop_h = c.ch;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_cmd(c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sb.expected.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 5'(idx * 4);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_regs(int pw, int ph, int ma, int mca, int ca);
    wait_drained();
    write_reg(REG_PATCH_W, pw);
    write_reg(REG_PATCH_H, ph);
    write_reg(REG_MERGE_ALPHA, ma);
    write_reg(REG_MCOLL_ALPHA, mca);
    write_reg(REG_COLL_ALPHA, ca);
  endtask

  function automatic cmd_s mk(logic [1:0] k, int node, int upd, int x, int y, int w,
                              int h, int cx = 0, int cy = 0, int cw = 100, int ch = 100);
    return '{k, 16'(node), 1'(upd), 16'(x), 16'(y), 15'(w), 15'(h),
             16'(cx), 16'(cy), 15'(cw), 15'(ch)};
  endfunction

  // Mostly small overlapping rectangles in a few groups so joins happen often;
  // a tenth are fully random beats.
  function automatic cmd_s rand_cmd(int ins_pct, int pop_pct);
    cmd_s c;
    int sel, crop_sel;
    if ($urandom_range(9) == 0) begin
      c = '{2'($urandom), 16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
            15'($urandom), 15'($urandom), 16'($urandom), 16'($urandom),
            15'($urandom), 15'($urandom)};
      return c;
    end
    sel = $urandom_range(99);
    crop_sel = $urandom_range(2);
    c = mk(sel < ins_pct ? KIND_INSERT : (sel < ins_pct + pop_pct ? KIND_POP : KIND_OPTIMIZE),
           $urandom_range(3), $urandom_range(1),
           $urandom_range(200) - 100, $urandom_range(200) - 100,
           $urandom_range(80), $urandom_range(80),
           crop_sel == 0 ? 0 : -32768, crop_sel == 2 ? 32767 : 0,
           crop_sel == 1 ? 32767 : 640, 480);
    return c;
  endfunction

  initial begin
    int pw, ph, ma, mca, ca, ins_pct, pop_pct;
    sb = new();
    items_sent = 0;
    sender_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_kind = KIND_INSERT;
    in_node_id = '0;
    in_update_type = 1'b0;
    in_rect_x = '0;
    in_rect_y = '0;
    in_rect_w = '0;
    in_rect_h = '0;
    in_crop_x = '0;
    in_crop_y = '0;
    in_crop_w = '0;
    in_crop_h = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset settings.
    send_cmd(mk(KIND_POP, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_OPTIMIZE, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(2'd3, 65535, 1, -1, -1, 32767, 32767));
    send_cmd(mk(KIND_INSERT, 7, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_INSERT, 7, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_OPTIMIZE, 7, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_INSERT, 1, 1, 10, 10, 50, 50));
    send_cmd(mk(KIND_INSERT, 1, 1, 10, 10, 50, 50));
    send_cmd(mk(KIND_INSERT, 1, 1, 20, 20, 50, 50));
    send_cmd(mk(KIND_INSERT, 1, 0, 20, 20, 50, 50));
    send_cmd(mk(KIND_INSERT, 1, 1, 20, 20, 50, 50, 1, 0, 100, 100));
    send_cmd(mk(KIND_INSERT, 65535, 1, -32768, -32768, 32767, 32767,
                -32768, -32768, 32767, 32767));
    send_cmd(mk(KIND_INSERT, 0, 0, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
    send_cmd(mk(KIND_OPTIMIZE, 0, 0, 0, 0, 0, 0));
    repeat (8) send_cmd(mk(KIND_POP, 0, 0, 0, 0, 0, 0));

    // Out-of-range register indexes must leave the settings alone.
    wait_drained();
    write_reg(5, 32'hffff_ffff);
    write_reg(7, 32'h0);

    // Random phases: each with its own settings, mix and sender idling.
    for (int ph_i = 0; ph_i < 7; ph_i++) begin
      case (ph_i)
        0: begin pw = 512; ph = 512; ma = 256; mca = 256; ca = 256; end
        1: begin pw = 32767; ph = 32767; ma = 1023; mca = 1023; ca = 1023; end
        2: begin pw = 1; ph = 1; ma = 0; mca = 0; ca = 0; end
        3: begin pw = 100; ph = 120; ma = 400; mca = 300; ca = 700; end
        4: begin pw = 32767; ph = 1; ma = 600; mca = 1023; ca = 0; end
        default: begin
          pw = $urandom_range(32767, 1);
          ph = $urandom_range(32767, 1);
          ma = $urandom_range(1023);
          mca = $urandom_range(1023);
          ca = $urandom_range(1023);
        end
      endcase
      set_regs(pw, ph, ma, mca, ca);
      // Low pop rates in some phases let the queue fill and drop requests.
      ins_pct = (ph_i == 2 || ph_i == 5) ? 90 : 60;
      pop_pct = (ph_i == 2 || ph_i == 5) ? 3 : 28;
      case (ph_i % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 48;
        2: sender_idle_pct = 19;
        default: sender_idle_pct = 48;
      endcase
      for (int n = 0; n < RAND_ITEMS / 7; n++) begin
        send_cmd(rand_cmd(ins_pct, pop_pct));
        // Hold off once mid-phase until everything in flight has come back.
        if (n == 100) wait_drained();
      end
    end
    sender_idle_pct = 0;
    repeat (70) send_cmd(mk(KIND_POP, 0, 0, 0, 0, 0, 0));

    wait_drained();
    repeat (50) @(negedge clk);
    $display("Sent %0d commands through 7 register settings; %0d entries popped,",
             items_sent, sb.pops);
    $display("%0d inserts dropped on a full queue, %0d result beats checked.",
             sb.drops, sb.checked);
    if (sb.mismatches == 0 && sb.expected.size() == 0) begin
      $display("dirty_rect_coalescing_queue_top: match");
    end else begin
      $display("dirty_rect_coalescing_queue_top: mismatch");
    end
    $finish;
  end
endmodule
